FILE: design/tcht_pkg.sv
// shared types and codes of the touch calibrate and hit region tracker
`default_nettype none

package tcht_pkg;

    // sizes of the fixed fields
    localparam int COEF_W   = 32;
    localparam int RAW_W    = 12;
    localparam int COORD_W  = 16;
    localparam int CTL_W    = 8;
    localparam int KIND_W   = 3;
    localparam int ACC_W    = 46;
    localparam int PROD_W   = COEF_W + RAW_W + 1;
    localparam int FRAC_W   = 16;
    localparam int CIDX_W   = 3;
    localparam int RCOUNT_W = 5;

    // defaults of the top level parameters
    localparam int DEF_REGION_SLOTS = 16;
    localparam int DEF_DELAY_DEPTH  = 4;
    localparam int DEF_DROP_SAMPLES = 3;

    // request op codes
    localparam logic [1:0] OP_DOWN = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_MOVE = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] EV_RAW_DOWN = 3'd0;
    localparam logic [KIND_W-1:0] EV_RAW_UP   = 3'd1;
    localparam logic [KIND_W-1:0] EV_RAW_MOVE = 3'd2;
    localparam logic [KIND_W-1:0] EV_PRESS    = 3'd3;
    localparam logic [KIND_W-1:0] EV_INSIDE   = 3'd4;
    localparam logic [KIND_W-1:0] EV_MOVEOUT  = 3'd5;
    localparam logic [KIND_W-1:0] EV_RELEASE  = 3'd6;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_X_CONST    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_X_FROM_Y   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_X_FROM_X   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_Y_CONST    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_Y_FROM_Y   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_Y_FROM_X   = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_DIRECT     = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_REG_COUNT  = 3'd7;

    localparam logic [COEF_W-1:0] UNITY_COEF = 32'h0001_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] ye;
        logic [CTL_W-1:0]          ctl;
    } region_t;

    typedef struct packed {
        logic load;
        logic add;
    } mac_cmd_t;

endpackage

`default_nettype wire

FILE: design/tcht_mac.sv
// shared multiply-accumulate unit with floor shift and 16-bit saturation
`default_nettype none

module tcht_mac (
    input  wire logic                             clk,
    input  wire tcht_pkg::mac_cmd_t               cmd,
    input  wire logic signed [tcht_pkg::COEF_W-1:0] coef,
    input  wire logic [tcht_pkg::RAW_W-1:0]       sample,
    input  wire logic signed [tcht_pkg::COEF_W-1:0] konst,
    output logic signed [tcht_pkg::COORD_W-1:0]   sat_q
);
    import tcht_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-FRAC_W-1:0] shifted;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = ACC_W'(konst);
        end
        else if (cmd.add)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * $signed({1'b0, sample});
        acc_reg  <= acc_next;
    end

    // arithmetic shift is a floor division by 65536
    assign shifted = acc_reg[ACC_W-1:FRAC_W];

    always_comb
    begin
        if (shifted[ACC_W-FRAC_W-1:COORD_W-1] == '0 ||
            shifted[ACC_W-FRAC_W-1:COORD_W-1] == '1)
        begin
            sat_q = shifted[COORD_W-1:0];
        end
        else if (shifted[ACC_W-FRAC_W-1])
        begin
            sat_q = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            sat_q = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

FILE: design/tcht_hit.sv
// strict bounds compare of one point against one region, with offsets
`default_nettype none

module tcht_hit (
    input  wire logic signed [tcht_pkg::COORD_W-1:0] pt_x,
    input  wire logic signed [tcht_pkg::COORD_W-1:0] pt_y,
    input  wire tcht_pkg::region_t                   rgn,
    input  wire logic                                check_ctl,
    output logic                                     hit,
    output logic [tcht_pkg::COORD_W-1:0]             off_x,
    output logic [tcht_pkg::COORD_W-1:0]             off_y
);
    import tcht_pkg::*;

    logic inside_box;

    assign inside_box = ($signed(pt_x) > $signed(rgn.xs)) && ($signed(pt_x) < $signed(rgn.xe)) &&
                        ($signed(pt_y) > $signed(rgn.ys)) && ($signed(pt_y) < $signed(rgn.ye));

    // with check_ctl set, a slot owned by control zero never matches
    assign hit   = inside_box && (!check_ctl || (rgn.ctl != '0));
    assign off_x = pt_x - rgn.xs;
    assign off_y = pt_y - rgn.ys;

endmodule

`default_nettype wire

FILE: design/touch_calibrate_hit_region_tracker.sv
// touch calibrate and hit region tracker top level
//
// requests arrive on item_valid / item_stall; one request is taken only while the
// block is idle, so item_stall is high for the whole time a request is worked on.
// loads, downs, dropped samples and ignored moves are done while the block is idle.
// a calibrated move runs the shared multiply-accumulate unit through a load and
// two accumulates per coordinate (four products, one a cycle) and a store to the
// delay line; while the line is still filling it stops there, else it reads the
// delay line, then checks the active region or searches the region table one slot
// a cycle (up to the slots in use), and hands the result to the output register.
// results leave on result_valid / result_stall from an output register; a stalled
// result holds while the next request is already taken, and the block waits only
// when a second result is ready before the first one is gone.
// configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are taken
// every cycle and are meant for idle periods only.
// reset clears the tracking state, counters and output valid and loads the
// identity calibration; region slots and delay line entries hold nothing defined
// until written.
`default_nettype none

module touch_calibrate_hit_region_tracker #(
    parameter int REGION_SLOTS = tcht_pkg::DEF_REGION_SLOTS,
    parameter int DELAY_DEPTH  = tcht_pkg::DEF_DELAY_DEPTH,
    parameter int DROP_SAMPLES = tcht_pkg::DEF_DROP_SAMPLES
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // request channel
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire logic [1:0]                            op,
    input  wire logic [tcht_pkg::RAW_W-1:0]            raw_x,
    input  wire logic [tcht_pkg::RAW_W-1:0]            raw_y,
    input  wire logic [3:0]                            slot_index,
    input  wire logic signed [tcht_pkg::COORD_W-1:0]   slot_x_start,
    input  wire logic signed [tcht_pkg::COORD_W-1:0]   slot_x_end,
    input  wire logic signed [tcht_pkg::COORD_W-1:0]   slot_y_start,
    input  wire logic signed [tcht_pkg::COORD_W-1:0]   slot_y_end,
    input  wire logic [tcht_pkg::CTL_W-1:0]            slot_control,
    // result channel
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic [tcht_pkg::KIND_W-1:0]                event_kind,
    output logic [tcht_pkg::CTL_W-1:0]                 control_id,
    output logic [tcht_pkg::COORD_W-1:0]               offset_x,
    output logic [tcht_pkg::COORD_W-1:0]               offset_y,
    output logic [tcht_pkg::RAW_W-1:0]                 pass_x,
    output logic [tcht_pkg::RAW_W-1:0]                 pass_y,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tcht_pkg::CIDX_W-1:0]           cfg_index,
    input  wire logic [tcht_pkg::COEF_W-1:0]           cfg_data
);
    import tcht_pkg::*;

    localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_W  = $clog2(REGION_SLOTS + 1);
    localparam int PTR_W  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
    localparam int DROP_W = 3;
    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_X_MUL  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_X_ADD1 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_X_ADD2 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_Y_MUL  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_Y_ADD1 = 3'd4;
    localparam logic [STEP_W-1:0] STEP_Y_ADD2 = 3'd5;
    localparam logic [STEP_W-1:0] STEP_STORE  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAL,
        S_LOADPT,
        S_SEARCH,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic signed [COEF_W-1:0] kx_reg, kx_next, cxy_reg, cxy_next, cxx_reg, cxx_next;
    logic signed [COEF_W-1:0] ky_reg, ky_next, cyy_reg, cyy_next, cyx_reg, cyx_next;
    logic                     direct_reg, direct_next;
    logic [RCOUNT_W-1:0]      rcount_reg, rcount_next;

    logic [RAW_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic              pressed_reg, pressed_next;
    logic              act_valid_reg, act_valid_next;
    region_t           act_reg, act_next;
    logic [COORD_W-1:0] offx_reg, offx_next, offy_reg, offy_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [FILL_W-1:0] fill_reg, fill_next, fill_after;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rvalid_reg, rvalid_next;

    logic [KIND_W-1:0]  res_kind_reg, res_kind_next;
    logic [CTL_W-1:0]   res_ctl_reg, res_ctl_next;
    logic [COORD_W-1:0] res_ox_reg, res_ox_next, res_oy_reg, res_oy_next;
    logic [RAW_W-1:0]   res_px_reg, res_px_next, res_py_reg, res_py_next;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [CTL_W-1:0]   out_ctl_reg, out_ctl_next;
    logic [COORD_W-1:0] out_ox_reg, out_ox_next, out_oy_reg, out_oy_next;
    logic [RAW_W-1:0]   out_px_reg, out_px_next, out_py_reg, out_py_next;

    // memories
    region_t                     reg_mem [REGION_SLOTS];
    region_t                     rdata_reg;
    logic [2*COORD_W-1:0]        dly_mem [DELAY_DEPTH];
    logic [2*COORD_W-1:0]        pt_reg;
    logic                        reg_we, dly_we, rd_en;
    logic [SLOT_W-1:0]           reg_waddr;
    region_t                     reg_wdata;

    logic        item_accept, cfg_accept, out_free, slot_ok;
    logic [CNT_W-1:0] n_slots;

    mac_cmd_t                 mac_cmd;
    logic signed [COEF_W-1:0] mac_coef, mac_konst;
    logic [RAW_W-1:0]         mac_sample;
    logic signed [COORD_W-1:0] mac_q;

    region_t            hit_rgn;
    logic               hit_check_ctl, hit;
    logic [COORD_W-1:0] hit_off_x, hit_off_y;

    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign out_free    = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign event_kind   = out_kind_reg;
    assign control_id   = out_ctl_reg;
    assign offset_x     = out_ox_reg;
    assign offset_y     = out_oy_reg;
    assign pass_x       = out_px_reg;
    assign pass_y       = out_py_reg;

    // slot counts above the table search the whole table
    assign n_slots = ({{(32-RCOUNT_W){1'b0}}, rcount_reg} < 32'(REGION_SLOTS)) ?
                     CNT_W'(rcount_reg) : CNT_W'(REGION_SLOTS);
    assign slot_ok   = ({28'd0, slot_index} < 32'(REGION_SLOTS));
    assign reg_waddr = SLOT_W'(slot_index);
    assign reg_wdata = '{xs: slot_x_start, xe: slot_x_end, ys: slot_y_start,
                         ye: slot_y_end, ctl: slot_control};
    assign rd_en     = (state_reg == S_SEARCH) && (issue_reg < n_slots);

    tcht_mac u_mac (
        .clk    (clk),
        .cmd    (mac_cmd),
        .coef   (mac_coef),
        .sample (mac_sample),
        .konst  (mac_konst),
        .sat_q  (mac_q)
    );

    assign hit_rgn       = (state_reg == S_SEARCH) ? rdata_reg : act_reg;
    assign hit_check_ctl = (state_reg == S_SEARCH);

    tcht_hit u_hit (
        .pt_x      (pt_reg[COORD_W-1:0]),
        .pt_y      (pt_reg[2*COORD_W-1:COORD_W]),
        .rgn       (hit_rgn),
        .check_ctl (hit_check_ctl),
        .hit       (hit),
        .off_x     (hit_off_x),
        .off_y     (hit_off_y)
    );

    // operand selection for the shared multiply-accumulate unit
    always_comb
    begin
        mac_cmd    = '{load: 1'b0, add: 1'b0};
        mac_coef   = cxx_reg;
        mac_sample = sx_reg;
        mac_konst  = kx_reg;
        if (state_reg == S_CAL)
        begin
            unique case (step_reg)
                STEP_X_MUL:
                begin
                    mac_cmd.load = 1'b1;
                end
                STEP_X_ADD1:
                begin
                    mac_coef     = cxy_reg;
                    mac_sample   = sy_reg;
                    mac_cmd.add  = 1'b1;
                end
                STEP_Y_MUL:
                begin
                    mac_coef     = cyx_reg;
                    mac_konst    = ky_reg;
                    mac_cmd.load = 1'b1;
                end
                STEP_Y_ADD1:
                begin
                    mac_coef     = cyy_reg;
                    mac_sample   = sy_reg;
                    mac_cmd.add  = 1'b1;
                end
                STEP_X_ADD2, STEP_Y_ADD2:
                begin
                    mac_cmd.add  = 1'b1;
                end
                default:
                begin
                    mac_cmd = '{load: 1'b0, add: 1'b0};
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        kx_next        = kx_reg;
        cxy_next       = cxy_reg;
        cxx_next       = cxx_reg;
        ky_next        = ky_reg;
        cyy_next       = cyy_reg;
        cyx_next       = cyx_reg;
        direct_next    = direct_reg;
        rcount_next    = rcount_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        pressed_next   = pressed_reg;
        act_valid_next = act_valid_reg;
        act_next       = act_reg;
        offx_next      = offx_reg;
        offy_next      = offy_reg;
        drop_next      = drop_reg;
        fill_next      = fill_reg;
        fill_after     = fill_reg;
        ptr_next       = ptr_reg;
        px_next        = px_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        res_kind_next  = res_kind_reg;
        res_ctl_next   = res_ctl_reg;
        res_ox_next    = res_ox_reg;
        res_oy_next    = res_oy_reg;
        res_px_next    = res_px_reg;
        res_py_next    = res_py_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_kind_next  = out_kind_reg;
        out_ctl_next   = out_ctl_reg;
        out_ox_next    = out_ox_reg;
        out_oy_next    = out_oy_reg;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        reg_we         = 1'b0;
        dly_we         = 1'b0;

        if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_X_CONST:   kx_next     = cfg_data;
                CFG_X_FROM_Y:  cxy_next    = cfg_data;
                CFG_X_FROM_X:  cxx_next    = cfg_data;
                CFG_Y_CONST:   ky_next     = cfg_data;
                CFG_Y_FROM_Y:  cyy_next    = cfg_data;
                CFG_Y_FROM_X:  cyx_next    = cfg_data;
                CFG_DIRECT:    direct_next = cfg_data[0];
                CFG_REG_COUNT: rcount_next = cfg_data[RCOUNT_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if (op == OP_LOAD)
                    begin
                        reg_we = slot_ok;
                    end
                    else if (direct_reg)
                    begin
                        // raw kinds share the op codes
                        res_kind_next = {1'b0, op};
                        res_ctl_next  = '0;
                        res_ox_next   = '0;
                        res_oy_next   = '0;
                        res_px_next   = raw_x;
                        res_py_next   = raw_y;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        unique case (op)
                            OP_DOWN:
                            begin
                                drop_next      = '0;
                                fill_next      = '0;
                                ptr_next       = '0;
                                pressed_next   = 1'b1;
                                act_valid_next = 1'b0;
                            end
                            OP_UP:
                            begin
                                if (pressed_reg && act_valid_reg)
                                begin
                                    pressed_next  = 1'b0;
                                    res_kind_next = EV_RELEASE;
                                    res_ctl_next  = act_reg.ctl;
                                    res_ox_next   = offx_reg;
                                    res_oy_next   = offy_reg;
                                    res_px_next   = '0;
                                    res_py_next   = '0;
                                    state_next    = S_EMIT;
                                end
                            end
                            OP_MOVE:
                            begin
                                if (pressed_reg)
                                begin
                                    if (drop_reg < DROP_W'(DROP_SAMPLES))
                                    begin
                                        drop_next = drop_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        sx_next    = raw_x;
                                        sy_next    = raw_y;
                                        step_next  = STEP_X_MUL;
                                        state_next = S_CAL;
                                    end
                                end
                            end
                            OP_LOAD:
                            begin
                                reg_we = slot_ok;
                            end
                        endcase
                    end
                end
            end

            S_CAL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_Y_MUL)
                begin
                    px_next = mac_q;
                end
                if (step_reg == STEP_STORE)
                begin
                    dly_we   = 1'b1;
                    ptr_next = (ptr_reg == PTR_W'(DELAY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    if (fill_reg < FILL_W'(DELAY_DEPTH))
                    begin
                        fill_after = fill_reg + 1'b1;
                    end
                    fill_next = fill_after;
                    // still filling the delay line: nothing to report yet
                    state_next = (fill_after < FILL_W'(DELAY_DEPTH)) ? S_IDLE : S_LOADPT;
                end
            end

            S_LOADPT:
            begin
                issue_next = '0;
                state_next = act_valid_reg ? S_CHECK : S_SEARCH;
            end

            S_SEARCH:
            begin
                // reads run one slot ahead of the compare
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                rvalid_next = rd_en;
                if (rvalid_reg && hit)
                begin
                    act_valid_next = 1'b1;
                    act_next       = rdata_reg;
                    offx_next      = hit_off_x;
                    offy_next      = hit_off_y;
                    res_kind_next  = EV_PRESS;
                    res_ctl_next   = rdata_reg.ctl;
                    res_ox_next    = hit_off_x;
                    res_oy_next    = hit_off_y;
                    res_px_next    = '0;
                    res_py_next    = '0;
                    rvalid_next    = 1'b0;
                    state_next     = S_EMIT;
                end
                else if (!rvalid_reg && !rd_en)
                begin
                    pressed_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            S_CHECK:
            begin
                res_ctl_next = act_reg.ctl;
                res_px_next  = '0;
                res_py_next  = '0;
                if (hit)
                begin
                    offx_next     = hit_off_x;
                    offy_next     = hit_off_y;
                    res_kind_next = EV_INSIDE;
                    res_ox_next   = hit_off_x;
                    res_oy_next   = hit_off_y;
                end
                else
                begin
                    // moveout reports the last inside offsets
                    res_kind_next  = EV_MOVEOUT;
                    res_ox_next    = offx_reg;
                    res_oy_next    = offy_reg;
                    act_valid_next = 1'b0;
                    pressed_next   = 1'b0;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_ctl_next   = res_ctl_reg;
                    out_ox_next    = res_ox_reg;
                    out_oy_next    = res_oy_reg;
                    out_px_next    = res_px_reg;
                    out_py_next    = res_py_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            kx_reg        <= '0;
            cxy_reg       <= '0;
            cxx_reg       <= UNITY_COEF;
            ky_reg        <= '0;
            cyy_reg       <= UNITY_COEF;
            cyx_reg       <= '0;
            direct_reg    <= 1'b0;
            rcount_reg    <= '0;
            pressed_reg   <= 1'b0;
            act_valid_reg <= 1'b0;
            act_reg       <= '0;
            offx_reg      <= '0;
            offy_reg      <= '0;
            drop_reg      <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            issue_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            kx_reg        <= kx_next;
            cxy_reg       <= cxy_next;
            cxx_reg       <= cxx_next;
            ky_reg        <= ky_next;
            cyy_reg       <= cyy_next;
            cyx_reg       <= cyx_next;
            direct_reg    <= direct_next;
            rcount_reg    <= rcount_next;
            pressed_reg   <= pressed_next;
            act_valid_reg <= act_valid_next;
            act_reg       <= act_next;
            offx_reg      <= offx_next;
            offy_reg      <= offy_next;
            drop_reg      <= drop_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            issue_reg     <= issue_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        px_reg       <= px_next;
        res_kind_reg <= res_kind_next;
        res_ctl_reg  <= res_ctl_next;
        res_ox_reg   <= res_ox_next;
        res_oy_reg   <= res_oy_next;
        res_px_reg   <= res_px_next;
        res_py_reg   <= res_py_next;
        out_kind_reg <= out_kind_next;
        out_ctl_reg  <= out_ctl_next;
        out_ox_reg   <= out_ox_next;
        out_oy_reg   <= out_oy_next;
        out_px_reg   <= out_px_next;
        out_py_reg   <= out_py_next;
    end

    // region table
    always_ff @(posedge clk)
    begin
        if (reg_we)
        begin
            reg_mem[reg_waddr] <= reg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= reg_mem[issue_reg[SLOT_W-1:0]];
        end
    end

    // delay line of calibrated points, y in the upper half
    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            dly_mem[ptr_reg] <= {mac_q, px_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOADPT)
        begin
            pt_reg <= dly_mem[ptr_reg];
        end
    end

`ifndef NO_ASSERTIONS
    a_cal_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAL || state_reg == S_SEARCH) |-> pressed_reg)
        else $error("sample processed while not pressed");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DELAY_DEPTH))
        else $error("delay fill count beyond depth");

    a_drop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg <= DROP_W'(DROP_SAMPLES))
        else $error("drop count beyond limit");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (result_valid && state_reg == S_IDLE))
        else $error("result not moved to output register");

    a_check_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> act_valid_reg)
        else $error("active region check without active region");
`endif

endmodule

`default_nettype wire
